// ----- rtl/core/battery_level_interpolator_top_macros.svh -----
// Assertion macros shared by the battery level interpolator checkers.
// Each macro expects a signal named clk, and all but BLIS_ASSERT_ALWAYS one named rst, in the scope where it is used.
`ifndef BATTERY_LEVEL_INTERPOLATOR_TOP_MACROS_SVH
`define BATTERY_LEVEL_INTERPOLATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Check that is not masked by reset, for behavior right after reset.
`define BLIS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/blis_pkg.sv -----
// Package for the battery level interpolator: widths, the pipeline word types,
// reset curve and field helpers. It depends on nothing else.
`default_nettype none

package blis_pkg;

  localparam int REG_COUNT = 8;
  localparam int CFG_IDX_W = 3;
  localparam int BP_W      = 24;
  localparam int VOLT_W    = 16;
  localparam int LEVEL_W   = 8;
  localparam int PROD_W    = VOLT_W + LEVEL_W;
  localparam int QUO_W     = LEVEL_W;
  localparam int QIDX_W    = 3;

  typedef logic [BP_W-1:0] bp_t;

  // Reset curve, highest voltage first.
  localparam bp_t BP_RESET [REG_COUNT] = '{
    24'd768200, 24'd742560, 24'd716920, 24'd691280,
    24'd665660, 24'd640040, 24'd614420, 24'd512000
  };

  // Word handed along the breakpoint scan cells.
  typedef struct packed {
    logic [VOLT_W-1:0]  v;
    logic               found;
    logic [VOLT_W-1:0]  dv;
    logic [VOLT_W-1:0]  den;
    logic               neg;
    logic [LEVEL_W-1:0] dl_mag;
    logic [LEVEL_W-1:0] base;
  } scan_t;

  // Word handed along the divider cells.
  typedef struct packed {
    logic [PROD_W-1:0]  rem;
    logic [VOLT_W-1:0]  den;
    logic [QUO_W-1:0]   quo;
    logic               neg;
    logic [LEVEL_W-1:0] base;
  } div_t;

  function automatic logic [VOLT_W-1:0] bp_volt(input bp_t bp);
    return bp[BP_W-1:LEVEL_W];
  endfunction

  function automatic logic [LEVEL_W-1:0] bp_level(input bp_t bp);
    return bp[LEVEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/blis_interfaces.sv -----
// Channel interfaces of the battery level interpolator: sample, result and
// configuration write. Depends on blis_pkg.
`default_nettype none

interface blis_sample_if;
  import blis_pkg::*;
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_mv;
  modport source (output valid, output voltage_mv, input ready);
  modport sink (input valid, input voltage_mv, output ready);
endinterface

interface blis_result_if;
  import blis_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

interface blis_cfg_if;
  import blis_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BP_W-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/battery_level_interpolator_top.sv -----
// Top level of the battery level interpolator: curve registers, scan chain,
// multiplier, divider chain and output register. Uses blis_pkg and the cells.
//
//   Channel   Dir   Payload                 Handshake
//   sample    in    voltage_mv[15:0]        valid/ready
//   result    out   level[7:0]              valid/ready
//   cfg       in    index[2:0], data[23:0]  valid/ready, ready always high
//
// One word enters and one leaves per cycle while the result side is not stalled. The
// path is one scan cell per breakpoint, one multiply stage, eight divider cells (one
// quotient bit each) and the output register.
// Reset (synchronous, rst high) empties the pipeline and reloads the curve.
// Every stage holds its word under backpressure and bubbles close up, so a
// stalled result still lets samples enter while any stage is empty.
`default_nettype none

module battery_level_interpolator_top #(
  parameter int NUM_POINTS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  blis_sample_if.sink   sample,
  blis_result_if.source result,
  blis_cfg_if.sink      cfg
);
  import blis_pkg::*;

  // Curve registers.
  bp_t bp [REG_COUNT];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bp <= BP_RESET;
    end else if (cfg.valid) begin
      bp[cfg.index] <= cfg.data;
    end
  end

  // Scan chain, one cell per breakpoint.
  logic  sc_valid [NUM_POINTS+1];
  logic  sc_ready [NUM_POINTS+1];
  scan_t sc_data  [NUM_POINTS+1];

  always_comb begin
    sc_data[0]   = '0;
    sc_data[0].v = sample.voltage_mv;
  end
  assign sc_valid[0]  = sample.valid;
  assign sample.ready = sc_ready[0];

  for (genvar k = 0; k < NUM_POINTS; k++) begin : g_scan
    if (k == 0) begin : g_head
      blis_scan_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .first    (1'b1),
        .bp_cur   (bp[k]),
        .bp_prev  (bp[k]),
        .up_valid (sc_valid[k]),
        .up_ready (sc_ready[k]),
        .up_data  (sc_data[k]),
        .dn_valid (sc_valid[k+1]),
        .dn_ready (sc_ready[k+1]),
        .dn_data  (sc_data[k+1])
      );
    end else begin : g_body
      blis_scan_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .first    (1'b0),
        .bp_cur   (bp[k]),
        .bp_prev  (bp[k-1]),
        .up_valid (sc_valid[k]),
        .up_ready (sc_ready[k]),
        .up_data  (sc_data[k]),
        .dn_valid (sc_valid[k+1]),
        .dn_ready (sc_ready[k+1]),
        .dn_data  (sc_data[k+1])
      );
    end
  end

  // Multiply stage: slope numerator, or the last level when nothing hit.
  logic  mul_valid;
  div_t  mul_data;
  div_t  mul_next;
  scan_t sc_last;

  assign sc_last = sc_data[NUM_POINTS];

  always_comb begin
    mul_next = '0;
    if (sc_last.found) begin
      mul_next.rem  = PROD_W'(sc_last.dv) * PROD_W'(sc_last.dl_mag);
      mul_next.den  = sc_last.den;
      mul_next.neg  = sc_last.neg;
      mul_next.base = sc_last.base;
    end else begin
      mul_next.den  = VOLT_W'(1);
      mul_next.base = bp_level(bp[NUM_POINTS-1]);
    end
  end

  logic dv_valid [QUO_W+1];
  logic dv_ready [QUO_W+1];
  div_t dv_data  [QUO_W+1];

  assign sc_ready[NUM_POINTS] = !mul_valid || dv_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (sc_ready[NUM_POINTS]) begin
      mul_valid <= sc_valid[NUM_POINTS];
    end
  end

  always_ff @(posedge clk) begin
    if (sc_ready[NUM_POINTS]) begin
      mul_data <= mul_next;
    end
  end

  assign dv_valid[0] = mul_valid;
  assign dv_data[0]  = mul_data;

  // Divider chain, most significant quotient bit first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    blis_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .bit_idx  (QIDX_W'(QUO_W - 1 - j)),
      .up_valid (dv_valid[j]),
      .up_ready (dv_ready[j]),
      .up_data  (dv_data[j]),
      .dn_valid (dv_valid[j+1]),
      .dn_ready (dv_ready[j+1]),
      .dn_data  (dv_data[j+1])
    );
  end

  // Output register: apply the slope sign and add the segment base level.
  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic [LEVEL_W-1:0] level_next;
  div_t               dv_last;

  assign dv_last = dv_data[QUO_W];

  always_comb begin
    if (dv_last.neg) begin
      level_next = dv_last.base - dv_last.quo;
    end else begin
      level_next = dv_last.base + dv_last.quo;
    end
  end

  assign dv_ready[QUO_W] = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dv_ready[QUO_W]) begin
      out_valid <= dv_valid[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready[QUO_W]) begin
      out_level <= level_next;
    end
  end

  assign result.valid = out_valid;
  assign result.level = out_level;

endmodule

`default_nettype wire

// ----- rtl/core/blis_scan_cell.sv -----
// One breakpoint cell of the scan chain: checks the sample against its own
// breakpoint and captures the interpolation terms on the first hit. Uses blis_pkg.
`default_nettype none

module blis_scan_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           first,
  input  wire blis_pkg::bp_t  bp_cur,
  input  wire blis_pkg::bp_t  bp_prev,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire blis_pkg::scan_t up_data,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output blis_pkg::scan_t     dn_data
);
  import blis_pkg::*;

  logic               valid;
  scan_t              data;
  scan_t              data_next;
  logic               hit;
  logic [VOLT_W-1:0]  volt_cur;
  logic [VOLT_W-1:0]  volt_prev;
  logic [LEVEL_W-1:0] lev_cur;
  logic [LEVEL_W-1:0] lev_prev;

  assign volt_cur  = bp_volt(bp_cur);
  assign volt_prev = bp_volt(bp_prev);
  assign lev_cur   = bp_level(bp_cur);
  assign lev_prev  = bp_level(bp_prev);

  // The first breakpoint strictly below the sample selects the segment.
  assign hit = !up_data.found && (up_data.v > volt_cur);

  always_comb begin
    data_next = up_data;
    if (hit) begin
      data_next.found = 1'b1;
      data_next.base  = lev_cur;
      if (first) begin
        // Above the top of the curve: the first level, no slope term.
        data_next.dv     = '0;
        data_next.den    = VOLT_W'(1);
        data_next.neg    = 1'b0;
        data_next.dl_mag = '0;
      end else begin
        // The previous cell did not hit, so volt_prev >= v > volt_cur.
        data_next.dv  = up_data.v - volt_cur;
        data_next.den = volt_prev - volt_cur;
        data_next.neg = (lev_prev < lev_cur);
        if (lev_prev < lev_cur) begin
          data_next.dl_mag = lev_cur - lev_prev;
        end else begin
          data_next.dl_mag = lev_prev - lev_cur;
        end
      end
    end
  end

  // A bubble in this cell may always be filled.
  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

`default_nettype wire

// ----- rtl/core/blis_div_cell.sv -----
// One restoring division cell: settles a single quotient bit and passes the
// partial remainder on. Uses blis_pkg.
`default_nettype none

module blis_div_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [blis_pkg::QIDX_W-1:0] bit_idx,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire blis_pkg::div_t              up_data,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output blis_pkg::div_t                   dn_data
);
  import blis_pkg::*;

  logic              valid;
  div_t              data;
  div_t              data_next;
  logic [PROD_W-1:0] trial;

  // Divisor aligned to this cell's quotient bit.
  assign trial = PROD_W'(up_data.den) << bit_idx;

  always_comb begin
    data_next = up_data;
    if (up_data.rem >= trial) begin
      data_next.rem          = up_data.rem - trial;
      data_next.quo[bit_idx] = 1'b1;
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

`default_nettype wire

// ----- rtl/core/blis_checker.sv -----
// Port-level checks for the battery level interpolator, bound to the top level.
// Uses the assertion macros header.
`default_nettype none

`include "battery_level_interpolator_top_macros.svh"

module blis_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       sample_valid,
  input wire logic       sample_ready,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic       result_valid,
  input wire logic       result_ready,
  input wire logic [7:0] result_level
);

  // A stalled result keeps its word.
  `BLIS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
                    result_valid && $stable(result_level),
                    "result word changed while stalled")

  // With the output side free, every stage can move, so a sample is taken.
  `BLIS_ASSERT_SAME(a_sample_ready, sample_valid && (!result_valid || result_ready),
                    sample_ready, "sample stalled although the output side is free")

  // Configuration writes never wait.
  `BLIS_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

  // Reset empties the pipeline.
  `BLIS_ASSERT_ALWAYS(a_reset_empty, $past(rst), !result_valid, "result valid right after reset")

endmodule

bind battery_level_interpolator_top blis_checker u_blis_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .cfg_valid    (cfg.valid),
  .cfg_ready    (cfg.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .result_level (result.level)
);

`default_nettype wire

// ----- bench/battery_level_interpolator_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for battery_level_interpolator_top: drives voltage words and
// curve writes, predicts each charge level and checks every result word.
// Depends on blis_pkg, the blis channel interfaces and the top-level RTL.

module battery_level_interpolator_top_test;
  import blis_pkg::*;

  localparam int CURVE_POINTS   = 8;
  localparam int PIPE_LATENCY   = CURVE_POINTS + 10;
  localparam int IDLE_LIMIT     = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 200;

  typedef enum int {
    CURVE_RESET,
    CURVE_FALLING,
    CURVE_NARROW,
    CURVE_SCRAMBLED
  } curve_kind_t;

  logic clk = 1'b0;
  logic rst;

  blis_sample_if sample_ch ();
  blis_result_if result_ch ();
  blis_cfg_if    cfg_ch ();

  battery_level_interpolator_top #(
    .NUM_POINTS(CURVE_POINTS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  // Curve as the block holds it, and the curve the next load will write.
  bp_t curve_model [REG_COUNT];
  bp_t curve_next [REG_COUNT];

  logic [VOLT_W-1:0]  voltage_pending_q[$];
  logic [LEVEL_W-1:0] level_expected_q[$];

  int  error_count = 0;
  int  idle_cycles = 0;
  int  sample_gap_max = 0;
  int  result_stall_max = 0;
  int  sample_wait = 0;
  int  result_wait = 0;
  bit  sample_busy = 1'b0;
  bit  sample_taken = 1'b0;
  bit  result_taken = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Charge level for one voltage under the current curve.
  function automatic logic [LEVEL_W-1:0] level_for_voltage(input logic [VOLT_W-1:0] v);
    longint dv, dl, den, sum;
    logic [LEVEL_W-1:0] lvl;
    bit hit;
    hit = 1'b0;
    lvl = curve_model[CURVE_POINTS-1][LEVEL_W-1:0];
    for (int k = 0; k < CURVE_POINTS; k++) begin
      if (!hit && v > curve_model[k][BP_W-1:LEVEL_W]) begin
        hit = 1'b1;
        if (k == 0) begin
          lvl = curve_model[0][LEVEL_W-1:0];
        end else begin
          dv  = longint'(v) - longint'(curve_model[k][BP_W-1:LEVEL_W]);
          dl  = longint'(curve_model[k-1][LEVEL_W-1:0]) - longint'(curve_model[k][LEVEL_W-1:0]);
          den = longint'(curve_model[k-1][BP_W-1:LEVEL_W]) -
                longint'(curve_model[k][BP_W-1:LEVEL_W]);
          if (den <= 0) den = 1;
          // Signed division truncates toward zero; the sum wraps to 8 bits.
          sum = (dv * dl) / den + longint'(curve_model[k][LEVEL_W-1:0]);
          lvl = sum[LEVEL_W-1:0];
        end
      end
    end
    return lvl;
  endfunction

  // Sample every handshake at the rising edge: predict, check, update the curve.
  always @(posedge clk) begin
    logic [LEVEL_W-1:0] want;
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        level_expected_q.push_back(level_for_voltage(sample_ch.voltage_mv));
        sample_taken = 1'b1;
      end
      if (result_ch.valid && result_ch.ready) begin
        result_taken = 1'b1;
        if (level_expected_q.size() == 0) begin
          $error("level: unexpected result word, actual %0d", result_ch.level);
          error_count++;
        end else begin
          want = level_expected_q.pop_front();
          if (result_ch.level !== want) begin
            $error("level mismatch: expected %0d, actual %0d", want, result_ch.level);
            error_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) curve_model[cfg_ch.index] = cfg_ch.data;

      // Watchdog on cycles where no channel moves a word.
      if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("battery_level_interpolator_top regression: fail");
          $finish;
        end
      end
    end
  end

  // Voltage driver: presents queued words with a random gap after each one.
  always @(negedge clk) begin
    if (rst) begin
      sample_busy = 1'b0;
      sample_taken = 1'b0;
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_taken) begin
        sample_taken = 1'b0;
        sample_busy = 1'b0;
        sample_wait = $urandom_range(0, sample_gap_max);
      end
      if (!sample_busy) begin
        if (sample_wait > 0) begin
          sample_wait--;
        end else if (voltage_pending_q.size() != 0) begin
          sample_ch.voltage_mv <= voltage_pending_q.pop_front();
          sample_busy = 1'b1;
        end
      end
      sample_ch.valid <= sample_busy;
    end
  end

  // Result receiver: stalls for a random number of cycles after each word.
  always @(negedge clk) begin
    if (rst) begin
      result_taken = 1'b0;
      result_ch.ready <= 1'b0;
    end else begin
      if (result_taken) begin
        result_taken = 1'b0;
        result_wait = $urandom_range(0, result_stall_max);
      end
      if (result_wait > 0) begin
        result_wait--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Writes every breakpoint register from curve_next, one word per handshake.
  task automatic load_curve();
    bit done;
    for (int k = 0; k < REG_COUNT; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= CFG_IDX_W'(k);
      cfg_ch.data  <= curve_next[k];
      done = 1'b0;
      while (!done) begin
        @(posedge clk);
        done = cfg_ch.ready;
        @(negedge clk);
      end
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Blocks until every queued voltage has been answered.
  task automatic drain();
    while (voltage_pending_q.size() != 0 || sample_busy || level_expected_q.size() != 0)
      @(negedge clk);
  endtask

  // Fills curve_next with a curve of the given kind.
  task automatic make_curve(input curve_kind_t kind);
    int volt, step_max;
    bit rising_mix;
    rising_mix = $urandom_range(0, 1);
    volt = (kind == CURVE_NARROW) ? $urandom_range(100, 5000) : $urandom_range(2000, 65535);
    step_max = (kind == CURVE_NARROW) ? 300 : 9000;
    for (int k = 0; k < REG_COUNT; k++) begin
      case (kind)
        CURVE_RESET: begin
          curve_next[k] = BP_RESET[k];
        end
        CURVE_SCRAMBLED: begin
          curve_next[k] = bp_t'($urandom());
        end
        default: begin
          if (k > 0) volt = volt - $urandom_range(0, (volt < step_max) ? volt : step_max);
          // Levels either fall with the voltage or jump about freely.
          curve_next[k][BP_W-1:LEVEL_W] = VOLT_W'(volt);
          curve_next[k][LEVEL_W-1:0] = rising_mix ? LEVEL_W'($urandom()) :
                                       LEVEL_W'(255 - k * 32 - $urandom_range(0, 31));
        end
      endcase
    end
  endtask

  // Voltage near a breakpoint, between two neighbors, or anywhere.
  function automatic logic [VOLT_W-1:0] pick_voltage();
    int sel, k, v, a, b;
    sel = $urandom_range(0, 9);
    k = $urandom_range(0, REG_COUNT - 2);
    a = curve_next[k][BP_W-1:LEVEL_W];
    b = curve_next[k+1][BP_W-1:LEVEL_W];
    if (sel < 3) begin
      v = $urandom_range(0, 65535);
    end else if (sel < 7) begin
      v = a + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else begin
      v = (a > b) ? $urandom_range(a, b) : $urandom_range(b, a);
    end
    return VOLT_W'(v);
  endfunction

  initial begin
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.voltage_mv = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int k = 0; k < REG_COUNT; k++) curve_model[k] = BP_RESET[k];
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset curve: input extremes, exact breakpoints, one either side, midpoints.
    for (int k = 0; k < REG_COUNT; k++) curve_next[k] = BP_RESET[k];
    voltage_pending_q = '{16'd0, 16'd65535, 16'd3000, 16'd3001, 16'd2999, 16'd2950,
                          16'd2850, 16'd2450, 16'd2001, 16'd2000, 16'd1999, 16'd2200};
    drain();

    // Full-scale curve with rising levels, a repeated voltage and a zero breakpoint.
    curve_next = '{{16'd65535, 8'd0}, {16'd40000, 8'd255}, {16'd20000, 8'd0},
                   {16'd20000, 8'd255}, {16'd10000, 8'd255}, {16'd100, 8'd0},
                   {16'd1, 8'd255}, {16'd0, 8'd0}};
    load_curve();
    voltage_pending_q = '{16'd65535, 16'd40001, 16'd39999, 16'd20000, 16'd20001,
                          16'd5000, 16'd1, 16'd0};
    drain();

    // All register bits high, then all low.
    foreach (curve_next[k]) curve_next[k] = '1;
    load_curve();
    voltage_pending_q = '{16'd65535, 16'd0};
    drain();
    foreach (curve_next[k]) curve_next[k] = '0;
    load_curve();
    voltage_pending_q = '{16'd0, 16'd1};
    drain();

    // Random phases, each with its own curve and handshake pacing.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin make_curve(CURVE_RESET);     sample_gap_max = 0;  result_stall_max = 0;  end
        1: begin make_curve(CURVE_FALLING);   sample_gap_max = 19; result_stall_max = 19; end
        2: begin make_curve(CURVE_NARROW);    sample_gap_max = 0;  result_stall_max = 19; end
        3: begin make_curve(CURVE_SCRAMBLED); sample_gap_max = 19; result_stall_max = 0;  end
        4: begin make_curve(CURVE_FALLING);   sample_gap_max = 3;  result_stall_max = 5;  end
        default: begin
          make_curve(CURVE_SCRAMBLED);
          sample_gap_max = 19;
          result_stall_max = 19;
        end
      endcase
      load_curve();
      for (int n = 0; n < PHASE_ITEMS; n++) voltage_pending_q.push_back(pick_voltage());
      drain();
    end

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (error_count == 0 && level_expected_q.size() == 0) begin
      $display("battery_level_interpolator_top regression: pass");
    end else begin
      $display("battery_level_interpolator_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- battery_level_interpolator_top.f -----
+incdir+rtl/core
rtl/core/blis_pkg.sv
rtl/core/blis_interfaces.sv
rtl/core/blis_scan_cell.sv
rtl/core/blis_div_cell.sv
rtl/core/battery_level_interpolator_top.sv
rtl/core/blis_checker.sv
bench/battery_level_interpolator_top_test.sv
